/* rtl/core/assert_macros.svh */
// assertion macros shared by the timer table rtl
// no dependencies; define SYNTH to compile the checks out
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

`define ASSERT_ALWAYS(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("timer table check failed");

`define ASSERT_NEXT(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("timer table check failed");

`else

`define ASSERT_ALWAYS(label, clk, rst, expr)

`define ASSERT_NEXT(label, clk, rst, pre, post)

`endif

`endif

/* rtl/core/mstt_pkg.sv */
// shared types, codes and defaults for the timer table
// no dependencies
`default_nettype none

package mstt_pkg;

  localparam int SLOT_COUNT_DEF = 16;
  localparam int TIME_BITS_DEF  = 32;

  localparam logic [1:0] CMD_TICK   = 2'd0;
  localparam logic [1:0] CMD_ADD    = 2'd1;
  localparam logic [1:0] CMD_REMOVE = 2'd2;

  localparam logic [1:0] KIND_ADDED = 2'd0;
  localparam logic [1:0] KIND_FIRED = 2'd1;
  localparam logic [1:0] KIND_FULL  = 2'd2;

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] delay_us;
    logic        repeat_flag;
    logic        every_tick;
    logic [31:0] target_id;
    logic [31:0] tick_time_us;
  } req_word_t;

  typedef struct packed {
    logic [1:0]  event_kind;
    logic [31:0] event_id;
    logic [31:0] time_value_us;
    logic        last_of_run;
  } rsp_word_t;

  typedef enum logic [2:0] {
    EV_NONE,
    EV_ADD,
    EV_FULL,
    EV_TIMED,
    EV_PERTICK,
    EV_REMOVE,
    EV_FLUSH
  } ev_op_t;

  typedef struct packed {
    logic   load;
    logic   rd_en;
    ev_op_t ev_op;
  } dp_cmd_t;

  typedef struct packed {
    logic hold;
    logic cur_free;
    logic match;
    logic pend_valid;
  } dp_status_t;

endpackage

`default_nettype wire

/* rtl/core/mstt_ctrl.sv */
// controller for the timer table: command decode, slot scan and walk sequencing
// depends on mstt_pkg
`default_nettype none

module mstt_ctrl #(
  parameter int SLOT_COUNT = mstt_pkg::SLOT_COUNT_DEF,
  localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1,
  localparam int CNT_W = $clog2(SLOT_COUNT + 1)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_ready,
  input  logic [1:0]          req_command,
  output mstt_pkg::dp_cmd_t   cmd,
  output logic [IDX_W-1:0]    rd_addr,
  output logic [IDX_W-1:0]    ev_addr,
  input  mstt_pkg::dp_status_t status
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ADD,
    S_REMOVE,
    S_TIMED,
    S_PERTICK,
    S_FLUSH
  } state_t;

  localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(SLOT_COUNT);

  state_t           state;
  logic [CNT_W-1:0] rd_idx;
  logic             ev_valid;
  logic [IDX_W-1:0] ev_idx;
  logic             scan_end;

  assign req_ready = (state == S_IDLE) && !rst;
  assign scan_end  = (rd_idx == LAST_CNT);
  assign rd_addr   = rd_idx[IDX_W-1:0];

  always_comb begin
    cmd.load  = (state == S_IDLE) && req_valid;
    cmd.rd_en = 1'b0;
    cmd.ev_op = mstt_pkg::EV_NONE;
    ev_addr   = ev_idx;
    unique case (state)
      S_IDLE: begin
      end
      S_ADD: begin
        ev_addr = rd_idx[IDX_W-1:0];
        if (scan_end) begin
          cmd.ev_op = mstt_pkg::EV_FULL;
        end else if (status.cur_free) begin
          cmd.ev_op = mstt_pkg::EV_ADD;
        end
      end
      S_REMOVE: begin
        cmd.rd_en = !status.hold && !scan_end;
        if (ev_valid) cmd.ev_op = mstt_pkg::EV_REMOVE;
      end
      S_TIMED: begin
        cmd.rd_en = !status.hold && !scan_end;
        if (ev_valid) cmd.ev_op = mstt_pkg::EV_TIMED;
      end
      S_PERTICK: begin
        cmd.rd_en = !status.hold && !scan_end;
        if (ev_valid) cmd.ev_op = mstt_pkg::EV_PERTICK;
      end
      S_FLUSH: begin
        cmd.ev_op = mstt_pkg::EV_FLUSH;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      rd_idx   <= '0;
      ev_valid <= 1'b0;
      ev_idx   <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          rd_idx   <= '0;
          ev_valid <= 1'b0;
          if (req_valid) begin
            unique case (req_command)
              mstt_pkg::CMD_TICK:   state <= S_TIMED;
              mstt_pkg::CMD_ADD:    state <= S_ADD;
              mstt_pkg::CMD_REMOVE: state <= S_REMOVE;
              default:              state <= S_IDLE;
            endcase
          end
        end
        S_ADD: begin
          if (scan_end || status.cur_free) begin
            if (!status.hold) state <= S_IDLE;
          end else begin
            rd_idx <= rd_idx + 1'b1;
          end
        end
        S_REMOVE, S_TIMED, S_PERTICK: begin
          if (state == S_REMOVE && ev_valid && status.match) begin
            state    <= S_IDLE;
            ev_valid <= 1'b0;
          end else if (!status.hold) begin
            if (!ev_valid && scan_end) begin
              rd_idx <= '0;
              unique case (state)
                S_TIMED:   state <= S_PERTICK;
                S_PERTICK: state <= S_FLUSH;
                default:   state <= S_IDLE;
              endcase
            end else begin
              ev_valid <= !scan_end;
              ev_idx   <= rd_idx[IDX_W-1:0];
              if (!scan_end) rd_idx <= rd_idx + 1'b1;
            end
          end
        end
        S_FLUSH: begin
          if (!status.hold) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

/* rtl/core/mstt_dpath.sv */
// datapath for the timer table: slot memories, valid bits, id counter,
// timer arithmetic, pending result and output register; depends on mstt_pkg
`default_nettype none

module mstt_dpath #(
  parameter int SLOT_COUNT = mstt_pkg::SLOT_COUNT_DEF,
  parameter int TIME_BITS  = mstt_pkg::TIME_BITS_DEF,
  localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1
) (
  input  logic                  clk,
  input  logic                  rst,
  input  mstt_pkg::req_word_t   req,
  input  mstt_pkg::dp_cmd_t     cmd,
  input  logic [IDX_W-1:0]      rd_addr,
  input  logic [IDX_W-1:0]      ev_addr,
  output mstt_pkg::dp_status_t  status,
  output logic                  rsp_valid,
  input  logic                  rsp_ready,
  output mstt_pkg::rsp_word_t   rsp
);

  localparam logic [IDX_W:0] SLOT_LIM = (IDX_W + 1)'(SLOT_COUNT);

  logic [31:0]           ident_mem    [SLOT_COUNT];
  logic signed [TIME_BITS:0] rem_mem  [SLOT_COUNT];
  logic [TIME_BITS-1:0]  period_mem   [SLOT_COUNT];
  logic                  repeats_mem  [SLOT_COUNT];
  logic                  per_tick_mem [SLOT_COUNT];

  logic [31:0]               rd_ident;
  logic signed [TIME_BITS:0] rd_rem;
  logic [TIME_BITS-1:0]      rd_period;
  logic                      rd_repeats;
  logic                      rd_per_tick;

  mstt_pkg::req_word_t  item;
  mstt_pkg::rsp_word_t  pend_word;
  mstt_pkg::rsp_word_t  emit_word;
  mstt_pkg::rsp_word_t  out_next;
  logic                 pend_valid;
  logic [SLOT_COUNT-1:0] valid_q;
  logic [31:0]          id_counter;
  logic [31:0]          id_next;

  logic [TIME_BITS+31:0]     delay_ext;
  logic [TIME_BITS+31:0]     dt_ext;
  logic [TIME_BITS-1:0]      delay_t;
  logic [TIME_BITS-1:0]      dt_t;
  logic signed [TIME_BITS:0] period_s;
  logic signed [TIME_BITS:0] r_sub;
  logic signed [TIME_BITS:0] r_add;
  logic signed [TIME_BITS:0] r_next;
  logic signed [TIME_BITS:0] rem_wr;
  logic signed [TIME_BITS:0] rem_add;
  logic [TIME_BITS:0]        neg_r;
  logic [TIME_BITS:0]        tv_full;
  logic                      fire_due;
  logic                      in_range;
  logic                      valid_at;
  logic                      timed_fire;
  logic                      tick_fire;
  logic                      remove_match;
  logic                      emit;
  logic                      out_busy;
  logic                      hold;
  logic                      push_out;
  logic                      pend_set;
  logic                      pend_clr;
  logic                      vset;
  logic                      vclr;
  logic                      mem_add;
  logic                      mem_timed;

  function automatic logic [31:0] sat_out(input logic [TIME_BITS:0] v);
    logic [TIME_BITS-1:0] tb;
    logic [TIME_BITS+32:0] ext;
    tb  = v[TIME_BITS] ? {TIME_BITS{1'b1}} : v[TIME_BITS-1:0];
    ext = {33'b0, tb};
    return (|ext[TIME_BITS+32:32]) ? 32'hFFFF_FFFF : ext[31:0];
  endfunction

  assign delay_ext = {{TIME_BITS{1'b0}}, item.delay_us};
  assign dt_ext    = {{TIME_BITS{1'b0}}, item.tick_time_us};
  assign delay_t   = delay_ext[TIME_BITS-1:0];
  assign dt_t      = dt_ext[TIME_BITS-1:0];
  assign id_next   = id_counter + 32'd1;

  assign in_range = ({1'b0, ev_addr} < SLOT_LIM);
  assign valid_at = in_range ? valid_q[ev_addr] : 1'b0;

  // remaining time after this tick, and reload for recurring timers
  assign period_s = signed'({1'b0, rd_period});
  assign r_sub    = rd_rem - signed'({1'b0, dt_t});
  assign fire_due = r_sub[TIME_BITS] || (r_sub == '0);
  assign neg_r    = unsigned'(-r_sub);
  assign tv_full  = {1'b0, rd_period} + neg_r;
  assign r_add    = r_sub + period_s;
  assign r_next   = (r_add[TIME_BITS] || (r_add == '0)) ? period_s : r_add;
  assign rem_wr   = (fire_due && rd_repeats) ? r_next : r_sub;
  assign rem_add  = item.every_tick ? '0 : signed'({1'b0, delay_t});

  assign timed_fire   = valid_at && !rd_per_tick && fire_due;
  assign tick_fire    = valid_at && rd_per_tick;
  assign remove_match = valid_at && (rd_ident == item.target_id);

  assign emit = ((cmd.ev_op == mstt_pkg::EV_TIMED) && timed_fire) ||
                ((cmd.ev_op == mstt_pkg::EV_PERTICK) && tick_fire);
  assign out_busy = rsp_valid && !rsp_ready;

  always_comb begin
    emit_word.event_kind    = mstt_pkg::KIND_FIRED;
    emit_word.event_id      = rd_ident;
    emit_word.time_value_us = (cmd.ev_op == mstt_pkg::EV_TIMED) ? sat_out(tv_full)
                                                                 : sat_out({1'b0, dt_t});
    emit_word.last_of_run   = 1'b0;
  end

  always_comb begin
    unique case (cmd.ev_op)
      mstt_pkg::EV_TIMED, mstt_pkg::EV_PERTICK: hold = emit && pend_valid && out_busy;
      mstt_pkg::EV_ADD, mstt_pkg::EV_FULL:      hold = out_busy;
      mstt_pkg::EV_FLUSH:                       hold = pend_valid && out_busy;
      default:                                  hold = 1'b0;
    endcase
  end

  always_comb begin
    push_out  = 1'b0;
    pend_set  = 1'b0;
    pend_clr  = 1'b0;
    vset      = 1'b0;
    vclr      = 1'b0;
    mem_add   = 1'b0;
    mem_timed = 1'b0;
    out_next  = pend_word;
    if (!hold) begin
      unique case (cmd.ev_op)
        mstt_pkg::EV_ADD: begin
          push_out = 1'b1;
          vset     = 1'b1;
          mem_add  = 1'b1;
          out_next = '{mstt_pkg::KIND_ADDED, id_next, 32'd0, 1'b1};
        end
        mstt_pkg::EV_FULL: begin
          push_out = 1'b1;
          out_next = '{mstt_pkg::KIND_FULL, 32'd0, 32'd0, 1'b1};
        end
        mstt_pkg::EV_TIMED: begin
          mem_timed = valid_at && !rd_per_tick;
          if (timed_fire) begin
            push_out = pend_valid;
            pend_set = 1'b1;
            vclr     = !rd_repeats;
          end
        end
        mstt_pkg::EV_PERTICK: begin
          if (tick_fire) begin
            push_out = pend_valid;
            pend_set = 1'b1;
          end
        end
        mstt_pkg::EV_REMOVE: begin
          vclr = remove_match;
        end
        mstt_pkg::EV_FLUSH: begin
          push_out             = pend_valid;
          pend_clr             = 1'b1;
          out_next.last_of_run = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  assign status.hold       = hold;
  assign status.cur_free   = in_range && !valid_q[ev_addr];
  assign status.match      = remove_match;
  assign status.pend_valid = pend_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid  <= 1'b0;
      pend_valid <= 1'b0;
      valid_q    <= '0;
      id_counter <= '0;
    end else begin
      if (push_out) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      if (pend_set) begin
        pend_valid <= 1'b1;
      end else if (pend_clr) begin
        pend_valid <= 1'b0;
      end
      if (vset) valid_q[ev_addr] <= 1'b1;
      if (vclr) valid_q[ev_addr] <= 1'b0;
      if (mem_add) id_counter <= id_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) item <= req;
    if (push_out) rsp <= out_next;
    if (pend_set) pend_word <= emit_word;
  end

  // slot memories: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_add) begin
      ident_mem[ev_addr]    <= id_next;
      rem_mem[ev_addr]      <= rem_add;
      period_mem[ev_addr]   <= item.every_tick ? '0 : delay_t;
      repeats_mem[ev_addr]  <= item.every_tick ? 1'b0 : item.repeat_flag;
      per_tick_mem[ev_addr] <= item.every_tick;
    end else if (mem_timed) begin
      rem_mem[ev_addr] <= rem_wr;
    end
    if (cmd.rd_en) begin
      rd_ident    <= ident_mem[rd_addr];
      rd_rem      <= rem_mem[rd_addr];
      rd_period   <= period_mem[rd_addr];
      rd_repeats  <= repeats_mem[rd_addr];
      rd_per_tick <= per_tick_mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

/* rtl/core/multi_slot_software_timer_table_top.sv */
// add: scans the valid bits in slot order for a free slot, or answers full
// remove: one slot per cycle through the slot memory read port, stopping at the matching id
// tick: a timed pass and a per-tick pass over the slot memory, one slot per cycle
// while the output does not stall, then a flush of the last word
// one command at a time; req_ready is high whenever the controller is idle and out of reset
// reset (sync, high) clears valid bits, id counter and handshake; slot memory is not cleared
`default_nettype none
`include "assert_macros.svh"

module multi_slot_software_timer_table_top #(
  parameter int SLOT_COUNT = mstt_pkg::SLOT_COUNT_DEF,
  parameter int TIME_BITS  = mstt_pkg::TIME_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_ready,
  input  mstt_pkg::req_word_t req,
  output logic                rsp_valid,
  input  logic                rsp_ready,
  output mstt_pkg::rsp_word_t rsp
);

  localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  mstt_pkg::dp_cmd_t    dp_cmd;
  mstt_pkg::dp_status_t dp_status;
  logic [IDX_W-1:0]     rd_addr;
  logic [IDX_W-1:0]     ev_addr;
  logic                 cmd_taken;

  mstt_ctrl #(
    .SLOT_COUNT(SLOT_COUNT)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_ready   (req_ready),
    .req_command (req.command),
    .cmd         (dp_cmd),
    .rd_addr     (rd_addr),
    .ev_addr     (ev_addr),
    .status      (dp_status)
  );

  mstt_dpath #(
    .SLOT_COUNT(SLOT_COUNT),
    .TIME_BITS (TIME_BITS)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd       (dp_cmd),
    .rd_addr   (rd_addr),
    .ev_addr   (ev_addr),
    .status    (dp_status),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  assign cmd_taken = req_valid && req_ready &&
                     ((req.command == mstt_pkg::CMD_TICK) ||
                      (req.command == mstt_pkg::CMD_ADD) ||
                      (req.command == mstt_pkg::CMD_REMOVE));

  `ASSERT_NEXT(a_busy_after_cmd, clk, rst, cmd_taken, !req_ready)
  `ASSERT_ALWAYS(a_idle_pend_empty, clk, rst, !req_ready || !dp_status.pend_valid)
  `ASSERT_ALWAYS(a_hold_needs_stall, clk, rst, !dp_status.hold || (rsp_valid && !rsp_ready))

endmodule

`default_nettype wire
